/* sv/ccqe_pkg.sv */
// Shared types, codes and message tables for the charger command queue encoder.
package ccqe_pkg;

    localparam logic [0:0] OP_ENQUEUE = 1'b0;
    localparam logic [0:0] OP_DEQUEUE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic [3:0] CMD_ONOFF32   = 4'd0;
    localparam logic [3:0] CMD_ONOFF64   = 4'd1;
    localparam logic [3:0] CMD_VMODE     = 4'd2;
    localparam logic [3:0] CMD_OUT_VOLT  = 4'd3;
    localparam logic [3:0] CMD_OUT_CURR  = 4'd4;
    localparam logic [3:0] CMD_MOD_GROUP = 4'd5;
    localparam logic [3:0] CMD_QUERY     = 4'd6;

    localparam logic [7:0] REG_PROTOCOL  = 8'd0;
    localparam logic [7:0] REG_MON_GROUP = 8'd1;
    localparam logic [7:0] REG_MON_SUB   = 8'd2;
    localparam logic [7:0] REG_ERR_TYPE  = 8'd3;

    localparam logic [5:0] RST_PROTOCOL  = 6'h38;
    localparam logic [4:0] RST_MON_GROUP = 5'h1C;
    localparam logic [5:0] RST_MON_SUB   = 6'h00;
    localparam logic [7:0] RST_ERR_TYPE  = 8'hF0;

    localparam logic [7:0] BCAST_LIMIT = 8'd30;
    localparam logic [4:0] BCAST_GROUP = 5'd31;

    localparam logic [28:0] ID_ALL_ONES = 29'h1FFF_FFFF;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  command;
        logic signed [31:0] value;
        logic [7:0]  group_number;
        logic [7:0]  sub_address;
    } t_cmd_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [28:0] frame_id;
        logic [63:0] payload;
        logic [4:0]  queue_level;
    } t_result;

    // one stored command: 49 bits
    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] value;
        logic [4:0]  group;
        logic [7:0]  sub;
    } t_entry;

    typedef struct packed {
        logic   deq;
        t_entry entry;
    } t_op;

    typedef struct packed {
        logic [5:0] protocol;
        logic [4:0] mon_group;
        logic [5:0] mon_sub;
        logic [7:0] err_type;
    } t_cfg;

    function automatic logic [7:0] msg_type(input logic [3:0] cmd);
        logic [7:0] t;
        unique case (cmd)
            CMD_QUERY: t = 8'h50;
            default:   t = 8'h03;
        endcase
        return t;
    endfunction

    function automatic logic [15:0] msg_id(input logic [3:0] cmd);
        logic [15:0] id;
        unique case (cmd)
            CMD_ONOFF32:   id = 16'h0230;
            CMD_ONOFF64:   id = 16'h0232;
            CMD_VMODE:     id = 16'h0233;
            CMD_OUT_VOLT:  id = 16'h0021;
            CMD_OUT_CURR:  id = 16'h0022;
            CMD_MOD_GROUP: id = 16'h001A;
            CMD_QUERY:     id = 16'h0202;
            default:       id = 16'h0000;
        endcase
        return id;
    endfunction

endpackage

/* sv/charger_can_command_queue_encoder_core.sv */
// Top level: configuration registers, front end and back end of the command queue encoder.
//
// Usage
//   Command channel: drive i_cmd and raise i_start; the item transfers at the edge where
//   i_start is high and o_busy is low. o_busy rises when the 2-entry op buffer between
//   the front and back ends is full.
//   Result channel: o_done is high for one cycle with o_result; the receiver cannot stall,
//   so every result must be taken in that cycle.
//   Config channel: i_cfg_valid / o_cfg_ready (always ready) with i_cfg_index and
//   i_cfg_data; write only while no item is in flight. Unknown indexes are ignored.
//   Result path: an enqueue or a dequeue that finds the queue empty passes through the op
//   buffer and the registered result; a dequeue that pops an entry also passes through the
//   registered read of the command store and the S_BUILD state.
//   Throughput: back end retires one enqueue per cycle; a popping dequeue also visits S_BUILD.
//   Reset (synchronous, i_rst_n low) empties the queue, clears the saved payload and
//   loads the register defaults; store contents are left as they are.
module charger_can_command_queue_encoder_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  ccqe_pkg::t_cmd_in i_cmd,
    output logic              o_done,
    output ccqe_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    ccqe_pkg::t_cfg r_cfg;
    ccqe_pkg::t_op  w_op;
    logic           w_op_valid;
    logic           w_op_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.protocol  <= ccqe_pkg::RST_PROTOCOL;
            r_cfg.mon_group <= ccqe_pkg::RST_MON_GROUP;
            r_cfg.mon_sub   <= ccqe_pkg::RST_MON_SUB;
            r_cfg.err_type  <= ccqe_pkg::RST_ERR_TYPE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ccqe_pkg::REG_PROTOCOL:  r_cfg.protocol  <= i_cfg_data[5:0];
                ccqe_pkg::REG_MON_GROUP: r_cfg.mon_group <= i_cfg_data[4:0];
                ccqe_pkg::REG_MON_SUB:   r_cfg.mon_sub   <= i_cfg_data[5:0];
                ccqe_pkg::REG_ERR_TYPE:  r_cfg.err_type  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ccqe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_cmd      (i_cmd),
        .o_busy     (o_busy),
        .o_op_valid (w_op_valid),
        .o_op       (w_op),
        .i_op_pop   (w_op_pop)
    );

    ccqe_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_op_valid (w_op_valid),
        .i_op       (w_op),
        .o_op_pop   (w_op_pop),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

/* sv/ccqe_front.sv */
// Front end: accepts items, maps broadcast groups, buffers ops in a 2-entry queue.
module ccqe_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ccqe_pkg::t_cmd_in i_cmd,
    output logic             o_busy,
    output logic             o_op_valid,
    output ccqe_pkg::t_op    o_op,
    input  logic             i_op_pop
);

    ccqe_pkg::t_op r_q [2];
    logic          r_head, n_head;
    logic [1:0]    r_cnt, n_cnt;
    ccqe_pkg::t_op w_op;
    logic          w_push;
    logic          w_tail;

    always_comb begin
        w_op.deq           = (i_cmd.opcode == ccqe_pkg::OP_DEQUEUE);
        w_op.entry.command = i_cmd.command;
        w_op.entry.value   = i_cmd.value;
        if (i_cmd.group_number > ccqe_pkg::BCAST_LIMIT) begin
            w_op.entry.group = ccqe_pkg::BCAST_GROUP;
            w_op.entry.sub   = 8'd0;
        end else begin
            w_op.entry.group = i_cmd.group_number[4:0];
            w_op.entry.sub   = i_cmd.sub_address;
        end
    end

    assign o_busy     = r_cnt[1];
    assign w_push     = i_start && !o_busy;
    assign w_tail     = r_head ^ r_cnt[0];
    assign o_op_valid = (r_cnt != 2'd0);
    assign o_op       = r_q[r_head];

    always_comb begin
        n_head = r_head;
        n_cnt  = r_cnt;
        if (i_op_pop && o_op_valid) begin
            n_head = ~r_head;
            n_cnt  = n_cnt - 2'd1;
        end
        if (w_push) begin
            n_cnt = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[w_tail] <= w_op;
        end
    end

endmodule

/* sv/ccqe_back.sv */
// Back end: command store, push/pop bookkeeping and frame building.
module ccqe_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccqe_pkg::t_cfg    i_cfg,
    input  logic              i_op_valid,
    input  ccqe_pkg::t_op     i_op,
    output logic              o_op_pop,
    output logic              o_done,
    output ccqe_pkg::t_result o_result
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_BUILD = 1'b1;

    ccqe_pkg::t_entry  r_mem [QUEUE_DEPTH];
    ccqe_pkg::t_entry  r_rd_data;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]     r_count, n_count;
    logic [63:0]       r_last, n_last;
    logic              r_state, n_state;
    logic              r_done, n_done;
    ccqe_pkg::t_result r_res, n_res;
    logic              w_we;
    logic [31:0]       w_val;
    logic [28:0]       w_id;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        w_val = (r_rd_data.command == ccqe_pkg::CMD_QUERY) ? 32'd0 : r_rd_data.value;
        w_id  = (29'(i_cfg.protocol) << 22) + (29'(r_rd_data.group) << 17)
              + (29'(r_rd_data.sub) << 11) + (29'(i_cfg.mon_group) << 6)
              + 29'(i_cfg.mon_sub);
    end

    always_comb begin
        n_state  = r_state;
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        n_last   = r_last;
        n_done   = 1'b0;
        n_res    = r_res;
        o_op_pop = 1'b0;
        w_we     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    o_op_pop          = 1'b1;
                    n_res.frame_id    = '0;
                    n_res.payload     = r_last;
                    if (!i_op.deq) begin
                        n_done = 1'b1;
                        if (r_count < CW'(QUEUE_DEPTH)) begin
                            w_we         = 1'b1;
                            n_wr_ptr     = ptr_inc(r_wr_ptr);
                            n_count      = r_count + 1'b1;
                            n_res.status = ccqe_pkg::ST_OK;
                        end else begin
                            n_res.status = ccqe_pkg::ST_FULL;
                        end
                    end else if (r_count == '0) begin
                        n_done       = 1'b1;
                        n_res.status = ccqe_pkg::ST_EMPTY;
                    end else begin
                        // read data lands in r_rd_data at this edge
                        n_rd_ptr = ptr_inc(r_rd_ptr);
                        n_count  = r_count - 1'b1;
                        n_state  = S_BUILD;
                    end
                    n_res.queue_level = 5'(n_count);
                end
            end
            S_BUILD: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_rd_data.command <= ccqe_pkg::CMD_QUERY) begin
                    n_last         = {ccqe_pkg::msg_type(r_rd_data.command), i_cfg.err_type,
                                      ccqe_pkg::msg_id(r_rd_data.command), w_val};
                    n_res.status   = ccqe_pkg::ST_OK;
                    n_res.frame_id = w_id;
                end else begin
                    n_res.status   = ccqe_pkg::ST_UNKNOWN;
                    n_res.frame_id = ccqe_pkg::ID_ALL_ONES;
                end
                n_res.payload     = n_last;
                n_res.queue_level = 5'(r_count);
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_last   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            r_last   <= n_last;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wr_ptr] <= i_op.entry;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

/* sv/ccqe_checker.sv */
// Port-level checks for the command queue encoder, bound to the top level.
module ccqe_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_busy,
    input logic              o_done,
    input ccqe_pkg::t_result o_result
);

    // reset leaves nothing in flight
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_done && !o_busy))
        else $error("result or busy right after reset");

    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ccqe_pkg::ST_EMPTY) |-> (o_result.queue_level == 5'd0))
        else $error("empty status with nonzero level");

    a_unknown_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ccqe_pkg::ST_UNKNOWN)
            |-> (o_result.frame_id == ccqe_pkg::ID_ALL_ONES))
        else $error("unknown command without all-ones id");

    // no frame is built when nothing was popped
    a_noframe_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ccqe_pkg::ST_FULL
                    || o_result.status == ccqe_pkg::ST_EMPTY))
            |-> (o_result.frame_id == 29'd0))
        else $error("frame id on full or empty status");

endmodule

bind charger_can_command_queue_encoder_core ccqe_checker u_ccqe_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);

/* dv/charger_can_command_queue_encoder_core_tb.sv */
// Testbench for the charger command queue encoder: directed and random traffic against a frame predictor.
`timescale 1ns / 100ps

module charger_can_command_queue_encoder_core_tb;

    localparam int QDEPTH = 16;
    localparam int RAND_ITEMS = 1150;
    localparam int PHASE_ITEMS = 200;
    localparam int SETTLE_CYCLES = 5;

    localparam logic [3:0] CMD_FIRST_UNKNOWN = 4'd7;
    localparam logic [3:0] CMD_LAST_UNKNOWN  = 4'd15;
    localparam logic [7:0] REG_UNUSED        = 8'hA5;
    localparam logic [7:0] MT_SET            = 8'h03;
    localparam logic [7:0] MT_QUERY          = 8'h50;

    class frame_predictor;
        logic [5:0]        protocol;
        logic [4:0]        mon_group;
        logic [5:0]        mon_sub;
        logic [7:0]        err_type;
        ccqe_pkg::t_entry  store [QDEPTH];
        int unsigned       rd_ptr;
        int unsigned       level;
        logic [63:0]       last_payload;
        ccqe_pkg::t_result expected_frames [$];
        int unsigned       errors;

        function new();
            protocol     = ccqe_pkg::RST_PROTOCOL;
            mon_group    = ccqe_pkg::RST_MON_GROUP;
            mon_sub      = ccqe_pkg::RST_MON_SUB;
            err_type     = ccqe_pkg::RST_ERR_TYPE;
            rd_ptr       = 0;
            level        = 0;
            last_payload = '0;
            errors       = 0;
        endfunction

        function void write_reg(input logic [7:0] idx, input logic [7:0] data);
            case (idx)
                ccqe_pkg::REG_PROTOCOL:  protocol  = data[5:0];
                ccqe_pkg::REG_MON_GROUP: mon_group = data[4:0];
                ccqe_pkg::REG_MON_SUB:   mon_sub   = data[5:0];
                ccqe_pkg::REG_ERR_TYPE:  err_type  = data;
                default: ;
            endcase
        endfunction

        // returns 0 for command codes with no message definition
        function bit lookup_msg(input logic [3:0] cmd, output logic [7:0] mtype,
                                output logic [15:0] mid);
            mtype = MT_SET;
            mid   = '0;
            case (cmd)
                ccqe_pkg::CMD_ONOFF32:   mid = 16'h0230;
                ccqe_pkg::CMD_ONOFF64:   mid = 16'h0232;
                ccqe_pkg::CMD_VMODE:     mid = 16'h0233;
                ccqe_pkg::CMD_OUT_VOLT:  mid = 16'h0021;
                ccqe_pkg::CMD_OUT_CURR:  mid = 16'h0022;
                ccqe_pkg::CMD_MOD_GROUP: mid = 16'h001A;
                ccqe_pkg::CMD_QUERY: begin
                    mtype = MT_QUERY;
                    mid   = 16'h0202;
                end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void note_command(input ccqe_pkg::t_cmd_in c);
            ccqe_pkg::t_result r;
            ccqe_pkg::t_entry  e;
            logic [31:0]       id_sum;
            logic [7:0]        mtype;
            logic [15:0]       mid;
            r = '0;
            r.status = ccqe_pkg::ST_OK;
            if (c.opcode == ccqe_pkg::OP_ENQUEUE) begin
                if (level < QDEPTH) begin
                    e.command = c.command;
                    e.value   = c.value;
                    if (c.group_number > ccqe_pkg::BCAST_LIMIT) begin
                        e.group = ccqe_pkg::BCAST_GROUP;
                        e.sub   = '0;
                    end else begin
                        e.group = c.group_number[4:0];
                        e.sub   = c.sub_address;
                    end
                    store[(rd_ptr + level) % QDEPTH] = e;
                    level++;
                end else begin
                    r.status = ccqe_pkg::ST_FULL;
                end
            end else if (level == 0) begin
                r.status = ccqe_pkg::ST_EMPTY;
            end else begin
                e = store[rd_ptr];
                rd_ptr = (rd_ptr + 1) % QDEPTH;
                level--;
                if (lookup_msg(e.command, mtype, mid)) begin
                    // sub-address is not clipped: values above 63 carry into the group bits
                    id_sum = (32'(protocol) << 22) + (32'(e.group) << 17) + (32'(e.sub) << 11)
                           + (32'(mon_group) << 6) + 32'(mon_sub);
                    r.frame_id   = id_sum[28:0];
                    last_payload = {mtype, err_type, mid,
                                    (e.command == ccqe_pkg::CMD_QUERY) ? 32'd0 : e.value};
                end else begin
                    r.status   = ccqe_pkg::ST_UNKNOWN;
                    r.frame_id = ccqe_pkg::ID_ALL_ONES;
                end
            end
            r.payload     = last_payload;
            r.queue_level = 5'(level);
            expected_frames = {expected_frames, r};
        endfunction

        function void check_frame(input ccqe_pkg::t_result got);
            ccqe_pkg::t_result want;
            if (expected_frames.size() == 0) begin
                $error("result with no transfer pending: status %0d id %h", got.status,
                       got.frame_id);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.frame_id !== want.frame_id) begin
                $error("frame_id: expected %h, got %h", want.frame_id, got.frame_id);
                errors++;
            end
            if (got.payload !== want.payload) begin
                $error("payload: expected %h, got %h", want.payload, got.payload);
                errors++;
            end
            if (got.queue_level !== want.queue_level) begin
                $error("queue_level: expected %0d, got %0d", want.queue_level, got.queue_level);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              o_busy;
    ccqe_pkg::t_cmd_in i_cmd = '0;
    logic              o_done;
    ccqe_pkg::t_result o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [7:0]        i_cfg_index = '0;
    logic [7:0]        i_cfg_data = '0;

    frame_predictor predictor;

    charger_can_command_queue_encoder_core #(
        .QUEUE_DEPTH(QDEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            predictor.check_frame(o_result);
    end

    // start stays high across back-to-back transfers; this task lowers it only for a gap
    task automatic send_cmd(input ccqe_pkg::t_cmd_in c, input int gap);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start = 1'b1;
        i_cmd   = c;
        do @(posedge i_clk); while (o_busy);
        predictor.note_command(c);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_start = 1'b0;
        while (predictor.expected_frames.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] idx, input logic [7:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        predictor.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic directed_enq(input logic [3:0] cmd, input logic [31:0] value,
                                input logic [7:0] grp, input logic [7:0] sub);
        ccqe_pkg::t_cmd_in c;
        c.opcode       = ccqe_pkg::OP_ENQUEUE;
        c.command      = cmd;
        c.value        = value;
        c.group_number = grp;
        c.sub_address  = sub;
        send_cmd(c, $urandom_range(0, 4));
    endtask

    task automatic configure_phase(input int phase);
        logic [7:0] vals [4];
        case (phase)
            0: vals = '{8'h00, 8'h00, 8'h00, 8'h00};
            1: vals = '{8'h3F, 8'h1F, 8'h3F, 8'hFF};
            2: vals = '{8'h00, 8'hFF, 8'h00, 8'hFF};
            3: vals = '{8'(ccqe_pkg::RST_PROTOCOL), 8'(ccqe_pkg::RST_MON_GROUP),
                        8'(ccqe_pkg::RST_MON_SUB), ccqe_pkg::RST_ERR_TYPE};
            default: vals = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
        endcase
        write_cfg(ccqe_pkg::REG_PROTOCOL, vals[0]);
        write_cfg(ccqe_pkg::REG_MON_GROUP, vals[1]);
        write_cfg(ccqe_pkg::REG_MON_SUB, vals[2]);
        write_cfg(ccqe_pkg::REG_ERR_TYPE, vals[3]);
        if (phase == 3)
            write_cfg(REG_UNUSED, 8'($urandom));
    endtask

    function automatic ccqe_pkg::t_cmd_in rand_cmd(input logic op);
        ccqe_pkg::t_cmd_in c;
        c.opcode = op;
        if ($urandom_range(0, 4) == 0)
            c.command = 4'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN));
        else
            c.command = 4'($urandom_range(ccqe_pkg::CMD_ONOFF32, ccqe_pkg::CMD_QUERY));
        c.value = $urandom;
        if ($urandom_range(0, 2) != 0)
            c.group_number = 8'($urandom_range(0, ccqe_pkg::BCAST_LIMIT));
        else
            c.group_number = 8'($urandom);
        c.sub_address = 8'($urandom);
        return c;
    endfunction

    initial begin
        int                sent;
        int                in_phase;
        int                phase;
        int                kind;
        int                len;
        bit                no_gaps;
        logic              op;
        ccqe_pkg::t_cmd_in c;

        predictor = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: reset registers, empty pop, every command, field extremes
        c = '0;
        c.opcode = ccqe_pkg::OP_DEQUEUE;
        send_cmd(c, 0);
        directed_enq(ccqe_pkg::CMD_ONOFF32, 32'h7FFF_FFFF, 8'd0, 8'd0);
        directed_enq(ccqe_pkg::CMD_ONOFF64, 32'h8000_0000, ccqe_pkg::BCAST_LIMIT, 8'd63);
        directed_enq(ccqe_pkg::CMD_VMODE, 32'h0000_0000, 8'd31, 8'd255);
        directed_enq(ccqe_pkg::CMD_OUT_VOLT, 32'hFFFF_FFFF, 8'd255, 8'd17);
        directed_enq(ccqe_pkg::CMD_OUT_CURR, $urandom, 8'd5, 8'd64);
        directed_enq(ccqe_pkg::CMD_MOD_GROUP, $urandom, ccqe_pkg::BCAST_LIMIT, 8'd255);
        directed_enq(ccqe_pkg::CMD_QUERY, 32'hDEAD_BEEF, 8'd1, 8'd1);
        directed_enq(CMD_FIRST_UNKNOWN, $urandom, 8'd2, 8'd2);
        directed_enq(CMD_LAST_UNKNOWN, $urandom, 8'd3, 8'd3);
        directed_enq(ccqe_pkg::CMD_ONOFF32, 32'h5555_AAAA, 8'h1F, 8'hAA);
        c.opcode = ccqe_pkg::OP_DEQUEUE;
        repeat (11) send_cmd(c, $urandom_range(0, 4));

        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            wait_drained();
            configure_phase(phase);
            phase++;
            in_phase = 0;
            while (in_phase < PHASE_ITEMS && sent < RAND_ITEMS) begin
                // bursts of mostly pushes reach full, mostly pops reach empty
                kind    = $urandom_range(0, 2);
                len     = $urandom_range(4, 24);
                no_gaps = ($urandom_range(0, 3) == 0);
                repeat (len) begin
                    case (kind)
                        0: op = ($urandom_range(0, 7) == 0) ? ccqe_pkg::OP_DEQUEUE
                                                             : ccqe_pkg::OP_ENQUEUE;
                        1: op = ($urandom_range(0, 7) == 0) ? ccqe_pkg::OP_ENQUEUE
                                                             : ccqe_pkg::OP_DEQUEUE;
                        default: op = $urandom_range(0, 1) ? ccqe_pkg::OP_DEQUEUE
                                                           : ccqe_pkg::OP_ENQUEUE;
                    endcase
                    send_cmd(rand_cmd(op), no_gaps ? 0 : $urandom_range(0, 4));
                    sent++;
                    in_phase++;
                end
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        if (predictor.errors == 0)
            $display("** charger_can_command_queue_encoder_core: PASSED **");
        else
            $display("** charger_can_command_queue_encoder_core: FAILED **");
        $finish;
    end

    initial begin
        #4ms;
        $display("** charger_can_command_queue_encoder_core: FAILED **");
        $finish;
    end

endmodule

/* charger_can_command_queue_encoder_core.f */
sv/ccqe_pkg.sv
sv/ccqe_front.sv
sv/ccqe_back.sv
sv/charger_can_command_queue_encoder_core.sv
sv/ccqe_checker.sv
dv/charger_can_command_queue_encoder_core_tb.sv
